### rtl/sconv_pkg.sv
// ----------------------------------------------------------------------------
// sconv_pkg
// Shared types and constants of the symmetric 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package sconv_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_FRAC_BITS = 10;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;
	localparam int IMG_W_W = 12;
	localparam int IMG_H_W = 16;
	localparam int ROW_W = 17;

	localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_CORNER_WT    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_EDGE_WT      = 3'd3;
	localparam logic [CFG_AW-1:0] REG_CENTRE_WT    = 3'd4;

	localparam logic signed [15:0] CENTRE_RESET = 16'sd1024;

	localparam int SUM_W = 10;
	localparam int PROD_W = 27;
	localparam int ACC_W = 29;
	localparam logic [7:0] PIX_MAX = 8'd255;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = 3;
	localparam int FIFO_CW = 4;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef pixel_t [2:0] column_t;
	typedef column_t [2:0] window_t;

	typedef struct packed {
		pixel_t upper;
		pixel_t middle;
	} line_t;

	typedef struct packed {
		logic signed [15:0] corner_k;
		logic signed [15:0] edge_k;
		logic signed [15:0] centre_k;
	} kern_t;

	typedef struct packed {
		logic   valid;
		logic   first;
		logic   up_ok;
		logic   mid_ok;
		logic   emit;
		logic   last;
		logic   restart;
		pixel_t px;
	} stage_t;

	typedef struct packed {
		logic   last;
		pixel_t pix;
	} result_t;

	function automatic logic [7:0] chan_of(input pixel_t p, input logic [1:0] k);
		case (k)
			2'd0: return p.red;
			2'd1: return p.green;
			default: return p.blue;
		endcase
	endfunction

endpackage

### rtl/sconv_ctrl.sv
// ----------------------------------------------------------------------------
// sconv_ctrl
// Configuration registers, raster position counters and the first stage.
// ----------------------------------------------------------------------------
module sconv_ctrl #(
	parameter int MAX_WIDTH = sconv_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sconv_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [sconv_pkg::CFG_DW-1:0] cfg_wdata,
	input  logic                         acc,
	input  logic                         action,
	input  sconv_pkg::pixel_t            pixel,
	output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output sconv_pkg::stage_t            stg_s1,
	output logic [$clog2(MAX_WIDTH)-1:0] addr_s1,
	output sconv_pkg::kern_t             kern
);
	import sconv_pkg::*;

	localparam int CNT_W = $clog2(MAX_WIDTH);
	localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
	localparam int TOT_W = WEFF_W + IMG_H_W;

	logic [WEFF_W-1:0]  weff_q;
	logic [IMG_H_W-1:0] heff_q;
	logic [TOT_W-1:0]   total_q;
	kern_t              kern_q;

	logic [CNT_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [TOT_W-1:0]   emitted_q;

	logic               restart, wrap, in_img, emit_now, last_now;
	logic [CNT_W-1:0]   col0, c, col_n;
	logic [ROW_W-1:0]   row0, r, row_n;
	logic [TOT_W-1:0]   em0, em_n;
	logic [WEFF_W-1:0]  c_next;
	pixel_t             px;

	function automatic logic [WEFF_W-1:0] eff_width(input logic [IMG_W_W-1:0] v);
		if (v == '0)
			return WEFF_W'(1);
		else if (32'(v) > MAX_WIDTH)
			return WEFF_W'(MAX_WIDTH);
		else
			return WEFF_W'(v);
	endfunction

	function automatic logic [IMG_H_W-1:0] eff_height(input logic [IMG_H_W-1:0] v);
		return (v == '0) ? IMG_H_W'(1) : v;
	endfunction

	function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] v);
		return (v == '1) ? v : v + ROW_W'(1);
	endfunction

	// config registers, sizes kept in effective form
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weff_q  <= WEFF_W'(1);
			heff_q  <= IMG_H_W'(1);
			total_q <= TOT_W'(1);
			kern_q  <= '{corner_k: '0, edge_k: '0, centre_k: CENTRE_RESET};
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH: begin
					weff_q  <= eff_width(cfg_wdata[IMG_W_W-1:0]);
					total_q <= TOT_W'(eff_width(cfg_wdata[IMG_W_W-1:0])) * TOT_W'(heff_q);
				end
				REG_IMAGE_HEIGHT: begin
					heff_q  <= eff_height(cfg_wdata[IMG_H_W-1:0]);
					total_q <= TOT_W'(weff_q) * TOT_W'(eff_height(cfg_wdata[IMG_H_W-1:0]));
				end
				REG_CORNER_WT: kern_q.corner_k <= signed'(cfg_wdata);
				REG_EDGE_WT:   kern_q.edge_k <= signed'(cfg_wdata);
				REG_CENTRE_WT: kern_q.centre_k <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign kern = kern_q;

	// position of the incoming pixel and next counter values
	always_comb begin
		restart  = emitted_q >= total_q;
		col0     = restart ? '0 : col_q;
		row0     = restart ? '0 : row_q;
		em0      = restart ? '0 : emitted_q;
		wrap     = WEFF_W'(col0) >= weff_q;
		c        = wrap ? '0 : col0;
		r        = wrap ? row_inc(row0) : row0;
		in_img   = r < ROW_W'(heff_q);
		px       = (action || !in_img) ? '0 : pixel;
		emit_now = (r >= ROW_W'(2)) || (r == ROW_W'(1) && c != '0);
		last_now = emit_now && (em0 == total_q - TOT_W'(1));
		c_next   = WEFF_W'(c) + WEFF_W'(1);
		if (c_next >= weff_q) begin
			col_n = '0;
			row_n = row_inc(r);
		end else begin
			col_n = CNT_W'(c_next);
			row_n = r;
		end
		em_n = em0 + TOT_W'(emit_now);
		if (last_now) begin
			col_n = '0;
			row_n = '0;
			em_n  = '0;
		end
	end

	assign rd_addr = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
			stg_s1    <= '0;
		end else begin
			stg_s1.valid <= acc;
			if (acc) begin
				col_q          <= col_n;
				row_q          <= row_n;
				emitted_q      <= em_n;
				stg_s1.first   <= (c == '0);
				stg_s1.up_ok   <= r >= ROW_W'(2);
				stg_s1.mid_ok  <= r >= ROW_W'(1);
				stg_s1.emit    <= emit_now;
				stg_s1.last    <= last_now;
				stg_s1.restart <= restart;
				stg_s1.px      <= px;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			addr_s1 <= c;
	end

`ifndef NO_ASSERTIONS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_now) |=> (col_q == '0 && row_q == '0 && emitted_q == '0))
		else $error("counters not cleared after last output");
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !cfg_we) |=> (WEFF_W'(col_q) < weff_q))
		else $error("column count left at or beyond width");
`endif

endmodule

### rtl/sconv_line.sv
// ----------------------------------------------------------------------------
// sconv_line
// Two line stores in one memory word, read ahead of the window stage,
// rewritten in the next cycle, with a bypass for back-to-back same column.
// ----------------------------------------------------------------------------
module sconv_line #(
	parameter int MAX_WIDTH = sconv_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  sconv_pkg::stage_t            stg,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	output sconv_pkg::line_t             rd_word
);
	import sconv_pkg::*;

	line_t mem [MAX_WIDTH];
	line_t rd_q, hold_q, wr_word;
	logic  fwd_q;

	assign rd_word = fwd_q ? hold_q : rd_q;
	assign wr_word = '{upper: rd_word.middle, middle: stg.px};

	always_ff @(posedge clk) begin
		if (stg.valid)
			mem[wr_addr] <= wr_word;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (stg.valid)
			hold_q <= wr_word;
	end

	// read issued during a write to the same column sees stale data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= rd_en && stg.valid && (rd_addr == wr_addr);
		end
	end

`ifndef NO_ASSERTIONS
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> $past(stg.valid && rd_en))
		else $error("bypass selected without a preceding write");
`endif

endmodule

### rtl/sconv_filt.sv
// ----------------------------------------------------------------------------
// sconv_filt
// 3x3 window, neighbour sums, weight products and clamp to 0..255.
// ----------------------------------------------------------------------------
module sconv_filt #(
	parameter int WEIGHT_FRAC_BITS = sconv_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sconv_pkg::stage_t  stg,
	input  sconv_pkg::line_t   line_rd,
	input  sconv_pkg::kern_t   kern,
	output logic               push,
	output sconv_pkg::result_t push_data,
	output logic [1:0]         pend
);
	import sconv_pkg::*;

	window_t win_q, base, shifted, win_d;
	column_t new_col;
	pixel_t  up, mid;

	logic                     v_s2, v_s3, last_s2, last_s3;
	logic [SUM_W-1:0]         corners_s2 [3];
	logic [SUM_W-1:0]         edges_s2 [3];
	logic [7:0]               centre_s2 [3];
	logic signed [PROD_W-1:0] pc_s3 [3];
	logic signed [PROD_W-1:0] pe_s3 [3];
	logic signed [PROD_W-1:0] pm_s3 [3];
	logic signed [ACC_W-1:0]  acc [3];
	logic signed [ACC_W-1:0]  scaled [3];
	logic [7:0]               ch_out [3];

	always_comb begin
		up         = stg.up_ok ? line_rd.upper : '0;
		mid        = stg.mid_ok ? line_rd.middle : '0;
		new_col[0] = up;
		new_col[1] = mid;
		new_col[2] = stg.px;
		base       = stg.restart ? '0 : win_q;
		shifted[0] = base[1];
		shifted[1] = base[2];
		shifted[2] = stg.first ? '0 : new_col;
		if (stg.last) begin
			win_d = '0;
		end else if (stg.first) begin
			win_d    = '0;
			win_d[2] = new_col;
		end else begin
			win_d = shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			if (stg.valid)
				win_q <= win_d;
			v_s2 <= stg.valid && stg.emit;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= stg.last;
		last_s3 <= last_s2;
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		always_ff @(posedge clk) begin
			corners_s2[ch] <= SUM_W'(chan_of(shifted[0][0], 2'(ch)))
				+ SUM_W'(chan_of(shifted[2][0], 2'(ch)))
				+ SUM_W'(chan_of(shifted[0][2], 2'(ch)))
				+ SUM_W'(chan_of(shifted[2][2], 2'(ch)));
			edges_s2[ch] <= SUM_W'(chan_of(shifted[1][0], 2'(ch)))
				+ SUM_W'(chan_of(shifted[0][1], 2'(ch)))
				+ SUM_W'(chan_of(shifted[2][1], 2'(ch)))
				+ SUM_W'(chan_of(shifted[1][2], 2'(ch)));
			centre_s2[ch] <= chan_of(shifted[1][1], 2'(ch));
		end

		always_ff @(posedge clk) begin
			pc_s3[ch] <= kern.corner_k * $signed({1'b0, corners_s2[ch]});
			pe_s3[ch] <= kern.edge_k * $signed({1'b0, edges_s2[ch]});
			pm_s3[ch] <= kern.centre_k * $signed({1'b0, centre_s2[ch]});
		end

		always_comb begin
			acc[ch]    = ACC_W'(pc_s3[ch]) + ACC_W'(pe_s3[ch]) + ACC_W'(pm_s3[ch]);
			scaled[ch] = acc[ch] >>> WEIGHT_FRAC_BITS;
			if (acc[ch] < 0)
				ch_out[ch] = '0;
			else if (scaled[ch] > ACC_W'(PIX_MAX))
				ch_out[ch] = PIX_MAX;
			else
				ch_out[ch] = scaled[ch][7:0];
		end
	end

	assign push                = v_s3;
	assign push_data.last      = last_s3;
	assign push_data.pix.red   = ch_out[0];
	assign push_data.pix.green = ch_out[1];
	assign push_data.pix.blue  = ch_out[2];
	assign pend                = {1'b0, v_s2} + {1'b0, v_s3};

endmodule

### rtl/sconv_fifo.sv
// ----------------------------------------------------------------------------
// sconv_fifo
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module sconv_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  sconv_pkg::result_t            push_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sconv_pkg::result_t            out_data,
	output logic [sconv_pkg::FIFO_CW-1:0] count
);
	import sconv_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != FIFO_CW'(FIFO_DEPTH)))
		else $error("result queue overflow");
`endif

endmodule

### rtl/symmetric_conv3x3_rgb.sv
// ----------------------------------------------------------------------------
// symmetric_conv3x3_rgb
// Streaming 3x3 RGB convolution with corner, edge and centre weights,
// zero padding, clamp to 0..255; two line stores hold the rows above.
//
//   channel  | signals                      | payload
//   ---------+------------------------------+--------------------------------
//   pixel in | s_tvalid s_tready            | s_tdata, s_tuser = flush tick
//   pixel out| m_tvalid m_tready            | m_tdata, m_tlast = last pixel
//   config   | cfg_we                       | cfg_addr, cfg_wdata
//
// One pixel per cycle while s_tready is high; a completed result goes through
// the first stage, sum and product registers and the queue to the output.
// The line store is one read and one write per cycle, bypassed when
// consecutive pixels hit the same entry, as in a single-column image.
// Reset clears counters, window and queue; line stores need no clearing.
// Input ready drops once queued plus in-flight results reach 8 entries.
// ----------------------------------------------------------------------------
module symmetric_conv3x3_rgb #(
	parameter int MAX_WIDTH = sconv_pkg::DEF_MAX_WIDTH,
	parameter int WEIGHT_FRAC_BITS = sconv_pkg::DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  sconv_pkg::pixel_t            s_tdata,   // in_red, in_green, in_blue
	input  logic                         s_tuser,   // action
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output sconv_pkg::pixel_t            m_tdata,   // out_red, out_green, out_blue
	output logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [sconv_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [sconv_pkg::CFG_DW-1:0] cfg_wdata
);
	import sconv_pkg::*;

	localparam int CNT_W = $clog2(MAX_WIDTH);

	logic               acc;
	logic [CNT_W-1:0]   rd_addr, addr_s1;
	stage_t             stg_s1;
	kern_t              kern;
	line_t              line_rd;
	logic               push;
	result_t            push_data, out_data;
	logic [1:0]         pend;
	logic [FIFO_CW-1:0] fifo_count, occ;

	// credit: queued results plus results still in flight
	assign occ = fifo_count + FIFO_CW'(stg_s1.valid && stg_s1.emit) + FIFO_CW'(pend);
	assign s_tready = occ < FIFO_CW'(FIFO_DEPTH);
	assign acc = s_tvalid && s_tready;

	sconv_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.acc      (acc),
		.action   (s_tuser),
		.pixel    (s_tdata),
		.rd_addr  (rd_addr),
		.stg_s1   (stg_s1),
		.addr_s1  (addr_s1),
		.kern     (kern)
	);

	sconv_line #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (acc),
		.rd_addr(rd_addr),
		.stg    (stg_s1),
		.wr_addr(addr_s1),
		.rd_word(line_rd)
	);

	sconv_filt #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_filt (
		.clk      (clk),
		.arst_n   (arst_n),
		.stg      (stg_s1),
		.line_rd  (line_rd),
		.kern     (kern),
		.push     (push),
		.push_data(push_data),
		.pend     (pend)
	);

	sconv_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_data),
		.count    (fifo_count)
	);

	assign m_tdata = out_data.pix;
	assign m_tlast = out_data.last;

endmodule
